// File: hdl/b64pc_pkg.sv
// Shared types, constants and the alphabet table for the base64url permuted codec.
`default_nettype none
package b64pc_pkg;

    localparam int LEN_BITS_DEFAULT = 16;
    localparam int CAP_W            = 16;
    localparam int OUT_LEN_W        = 16;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 32;
    localparam int CFG_ADDR_W       = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = 2;

    localparam logic [7:0] PAD_CHAR = 8'h51;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAP  = 2'd1;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_ENC_CAP   = 4'd1,
        ST_ENC_FULL  = 4'd2,
        ST_LEN       = 4'd3,
        ST_BAD_LEAD  = 4'd4,
        ST_BAD_THIRD = 4'd5,
        ST_ROOM3     = 4'd6,
        ST_ROOM2     = 4'd7,
        ST_ROOM1     = 4'd8
    } status_t;

    // One request from the front end to the back end: a status, or 1..4 bytes.
    typedef struct packed {
        logic            is_status;
        status_t         status;
        logic [2:0]      nbytes;
        logic [3:0][7:0] bytes;
        logic            fin;
    } job_t;

    localparam logic [7:0] ALPHABET [64] = '{
        "z", "A", "R", "i", "j", "0", "B", "S",
        "1", "C", "k", "T", "U", "D", "2", "l",
        "3", "m", "E", "V", "n", "F", "4", "W",
        "X", "5", "G", "o", "p", "H", "6", "Y",
        "7", "q", "Z", "I", "r", "J", "8", "a",
        "s", "K", "9", "b", "c", "t", "-", "L",
        "_", "M", "d", "u", "e", "v", "N", "w",
        "O", "f", "g", "x", "P", "=", "y", "h"
    };

    function automatic logic [7:0] enc_char(input logic [5:0] code);
        return ALPHABET[code];
    endfunction

    // Returns {not_in_alphabet, code}.
    function automatic logic [6:0] char_index(input logic [7:0] c);
        logic [6:0] idx;
        idx = 7'h40;
        for (int i = 0; i < 64; i++) begin
            if (ALPHABET[i] == c) begin
                idx = {1'b0, 6'(i)};
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// File: hdl/b64pc_front.sv
// Front end: message state, grouping, classification and error checks.
`default_nettype none
module b64pc_front #(
    parameter int LEN_BITS = b64pc_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_fire,
    input  wire logic [7:0]                        in_data,
    input  wire logic                              in_last,
    input  wire logic                              cfg_wr_en,
    input  wire logic [b64pc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [b64pc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output logic                                   push,
    output b64pc_pkg::job_t                        push_job,
    output logic [LEN_BITS-1:0]                    push_len
);

    localparam int CAP_W = b64pc_pkg::CAP_W;
    localparam logic [CAP_W-1:0] CAP_MASK =
        (LEN_BITS >= CAP_W) ? {CAP_W{1'b1}} : CAP_W'((64'd1 << LEN_BITS) - 64'd1);
    localparam int EXT_W = (LEN_BITS > CAP_W) ? LEN_BITS : CAP_W;
    localparam int CMP_W = EXT_W + 1;

    logic                 mode_reg,    mode_next;
    logic [CAP_W-1:0]     cap_reg,     cap_next;
    logic [23:0]          hold_reg,    hold_next;
    logic [1:0]           fill_reg,    fill_next;
    logic [LEN_BITS-1:0]  wc_reg,      wc_next;
    logic                 drain_reg,   drain_next;
    logic                 started_reg, started_next;

    logic                 do_fail;
    b64pc_pkg::status_t   fail_code;
    logic                 do_emit;
    logic [2:0]           emit_n;
    logic [3:0][7:0]      emit_bytes;
    logic [23:0]          hold_ins;
    logic [2:0]           n_enc;
    logic [6:0]           ci;
    logic [23:0]          dec_val;
    logic [2:0]           need;
    logic [CMP_W-1:0]     need_sum;
    logic                 room_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 1'b0;
            cap_reg     <= CAP_MASK;
            hold_reg    <= '0;
            fill_reg    <= '0;
            wc_reg      <= '0;
            drain_reg   <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            cap_reg     <= cap_next;
            hold_reg    <= hold_next;
            fill_reg    <= fill_next;
            wc_reg      <= wc_next;
            drain_reg   <= drain_next;
            started_reg <= started_next;
        end
    end

    assign ci = b64pc_pkg::char_index(in_data);

    always_comb begin
        mode_next    = mode_reg;
        cap_next     = cap_reg;
        hold_next    = hold_reg;
        fill_next    = fill_reg;
        wc_next      = wc_reg;
        drain_next   = drain_reg;
        started_next = started_reg;
        do_fail      = 1'b0;
        fail_code    = b64pc_pkg::ST_OK;
        do_emit      = 1'b0;
        emit_n       = 3'd0;
        emit_bytes   = '0;
        hold_ins     = hold_reg;
        n_enc        = {1'b0, fill_reg} + 3'd1;
        dec_val      = '0;
        need         = 3'd4;

        if (mode_reg == 1'b0) begin
            hold_ins = hold_reg | (24'(in_data) << {fill_reg, 3'b000});
            need     = 3'd4;
        end else begin
            case (fill_reg)
                2'd0:    hold_ins = hold_reg | 24'(ci[5:0]) | (24'(ci[6]) << 18);
                2'd1:    hold_ins = hold_reg | (24'(ci[5:0]) << 6) | (24'(ci[6]) << 19);
                default: hold_ins = hold_reg | (24'(ci[5:0]) << 12) | (24'(ci[6]) << 20);
            endcase
            if (!ci[6]) begin
                need    = 3'd3;
                dec_val = {ci[5:0], hold_reg[17:0]};
            end else if (!hold_reg[20]) begin
                need    = 3'd2;
                dec_val = {6'd0, hold_reg[17:0]};
            end else begin
                need    = 3'd1;
                dec_val = {12'd0, hold_reg[11:0]};
            end
        end

        need_sum = CMP_W'(wc_reg) + CMP_W'(need);
        room_ok  = need_sum <= CMP_W'(cap_reg);

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                b64pc_pkg::REG_MODE: begin
                    mode_next    = cfg_wr_data[0];
                    hold_next    = '0;
                    fill_next    = '0;
                    wc_next      = '0;
                    drain_next   = 1'b0;
                    started_next = 1'b0;
                end
                b64pc_pkg::REG_CAP: begin
                    cap_next = cfg_wr_data & CAP_MASK;
                end
                default: begin
                end
            endcase
        end else if (in_fire) begin
            if (drain_reg) begin
                if (in_last) begin
                    hold_next    = '0;
                    fill_next    = '0;
                    wc_next      = '0;
                    drain_next   = 1'b0;
                    started_next = 1'b0;
                end
            end else if (mode_reg == 1'b0) begin
                if (!started_reg && (cap_reg < CAP_W'(4))) begin
                    do_fail   = 1'b1;
                    fail_code = b64pc_pkg::ST_ENC_CAP;
                end else begin
                    started_next = 1'b1;
                    if ((n_enc < 3'd3) && !in_last) begin
                        hold_next = hold_ins;
                        fill_next = n_enc[1:0];
                    end else if (!room_ok) begin
                        do_fail   = 1'b1;
                        fail_code = b64pc_pkg::ST_ENC_FULL;
                    end else begin
                        do_emit       = 1'b1;
                        emit_n        = 3'd4;
                        emit_bytes[0] = b64pc_pkg::enc_char(hold_ins[5:0]);
                        emit_bytes[1] = b64pc_pkg::enc_char(hold_ins[11:6]);
                        emit_bytes[2] = (n_enc >= 3'd2) ?
                                        b64pc_pkg::enc_char(hold_ins[17:12]) :
                                        b64pc_pkg::PAD_CHAR;
                        emit_bytes[3] = (n_enc >= 3'd3) ?
                                        b64pc_pkg::enc_char(hold_ins[23:18]) :
                                        b64pc_pkg::PAD_CHAR;
                    end
                end
            end else begin
                started_next = 1'b1;
                if (fill_reg != 2'd3) begin
                    hold_next = hold_ins;
                    fill_next = fill_reg + 2'd1;
                    if (in_last) begin
                        do_fail   = 1'b1;
                        fail_code = b64pc_pkg::ST_LEN;
                    end
                end else if (hold_reg[18] || hold_reg[19]) begin
                    do_fail   = 1'b1;
                    fail_code = b64pc_pkg::ST_BAD_LEAD;
                end else if (!ci[6] && hold_reg[20]) begin
                    do_fail   = 1'b1;
                    fail_code = b64pc_pkg::ST_BAD_THIRD;
                end else if (!room_ok) begin
                    do_fail = 1'b1;
                    unique case (need)
                        3'd3:    fail_code = b64pc_pkg::ST_ROOM3;
                        3'd2:    fail_code = b64pc_pkg::ST_ROOM2;
                        default: fail_code = b64pc_pkg::ST_ROOM1;
                    endcase
                end else begin
                    do_emit       = 1'b1;
                    emit_n        = need;
                    emit_bytes[0] = dec_val[7:0];
                    emit_bytes[1] = dec_val[15:8];
                    emit_bytes[2] = dec_val[23:16];
                end
            end

            if (do_fail) begin
                hold_next = '0;
                fill_next = '0;
                if (in_last) begin
                    wc_next      = '0;
                    drain_next   = 1'b0;
                    started_next = 1'b0;
                end else begin
                    drain_next = 1'b1;
                end
            end
            if (do_emit) begin
                hold_next = '0;
                fill_next = '0;
                wc_next   = wc_reg + LEN_BITS'(emit_n);
                if (in_last) begin
                    wc_next      = '0;
                    started_next = 1'b0;
                end
            end
        end
    end

    always_comb begin
        push               = do_fail || do_emit;
        push_job.is_status = do_fail;
        push_job.status    = fail_code;
        push_job.nbytes    = emit_n;
        push_job.bytes     = emit_bytes;
        push_job.fin       = in_last;
        push_len           = wc_reg;
    end

`ifndef SYNTHESIS
    a_drain_empty_group: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> (fill_reg == 2'd0) && (hold_reg == 24'd0))
        else $error("partial group held while draining");
    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !started_reg |-> (wc_reg == '0))
        else $error("bytes counted outside a message");
`endif

endmodule
`default_nettype wire

// File: hdl/b64pc_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none
module b64pc_queue #(
    parameter int LEN_BITS = b64pc_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire b64pc_pkg::job_t      push_job,
    input  wire logic [LEN_BITS-1:0]  push_len,
    input  wire logic                 pop,
    output b64pc_pkg::job_t           head_job,
    output logic [LEN_BITS-1:0]       head_len,
    output logic                      full,
    output logic                      empty
);

    localparam int DEPTH = b64pc_pkg::QUEUE_DEPTH;
    localparam int AW    = b64pc_pkg::QUEUE_AW;

    b64pc_pkg::job_t       job_mem [DEPTH];
    logic [LEN_BITS-1:0]   len_mem [DEPTH];
    logic [AW-1:0]         wptr_reg, wptr_next;
    logic [AW-1:0]         rptr_reg, rptr_next;
    logic [AW:0]           count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            job_mem[wptr_reg] <= push_job;
            len_mem[wptr_reg] <= push_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        wptr_next  = push ? wptr_reg + AW'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + AW'(1) : rptr_reg;
        count_next = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = job_mem[rptr_reg];
    assign head_len = len_mem[rptr_reg];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("request pushed into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("request popped from an empty queue");
`endif

endmodule
`default_nettype wire

// File: hdl/b64pc_back.sv
// Back end: unrolls queued requests into one result per cycle while the sink is ready, behind an output register.
`default_nettype none
module b64pc_back #(
    parameter int LEN_BITS = b64pc_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire b64pc_pkg::job_t                       head_job,
    input  wire logic [LEN_BITS-1:0]                   head_len,
    input  wire logic                                  empty,
    output logic                                       pop,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [b64pc_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                       m_tuser,
    output logic                                       m_tlast
);

    localparam int OLW   = b64pc_pkg::OUT_LEN_W;
    localparam int EXT_W = (LEN_BITS > OLW) ? LEN_BITS : OLW;
    localparam int PAD_W = b64pc_pkg::OUT_TDATA_W - 12 - OLW;

    logic [1:0]                         k_reg, k_next;
    logic                               valid_reg, valid_next;
    logic [b64pc_pkg::OUT_TDATA_W-1:0]  tdata_reg, tdata_next;
    logic                               tuser_reg, tuser_next;
    logic                               tlast_reg, tlast_next;

    logic                               load;
    logic                               job_done;
    logic [LEN_BITS-1:0]                len_sel;
    logic [EXT_W-1:0]                   len_ext;
    logic [7:0]                         byte_sel;
    b64pc_pkg::status_t                 st_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end else begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
        tlast_reg <= tlast_next;
    end

    always_comb begin
        load     = !empty && (!valid_reg || m_tready);
        job_done = head_job.is_status || (({1'b0, k_reg} + 3'd1) == head_job.nbytes);
        pop      = load && job_done;

        if (head_job.is_status) begin
            len_sel  = head_len;
            byte_sel = 8'd0;
            st_sel   = head_job.status;
        end else begin
            len_sel  = head_len + LEN_BITS'(k_reg) + LEN_BITS'(1);
            byte_sel = head_job.bytes[k_reg];
            st_sel   = b64pc_pkg::ST_OK;
        end
        len_ext = EXT_W'(len_sel);

        k_next     = k_reg;
        valid_next = valid_reg;
        tdata_next = tdata_reg;
        tuser_next = tuser_reg;
        tlast_next = tlast_reg;

        if (load) begin
            valid_next = 1'b1;
            tdata_next = {{PAD_W{1'b0}}, len_ext[OLW-1:0], st_sel, byte_sel};
            tuser_next = !head_job.is_status;
            tlast_next = head_job.is_status || (head_job.fin && job_done);
            k_next     = job_done ? 2'd0 : k_reg + 2'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

`ifndef SYNTHESIS
    a_status_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !tuser_reg |-> tlast_reg)
        else $error("status result not marked final");
`endif

endmodule
`default_nettype wire

// File: hdl/base64url_permuted_codec_top.sv
// Top level of the base64url permuted-alphabet stream codec.
//
//  port group   dir  fields (low bit first)                        request taken when
//  s_*          in   tdata: data[7:0]; tlast: last                 s_tvalid & s_tready
//  m_*          out  tdata: out_byte, status, out_len, zero pad;   m_tvalid & m_tready
//                    tuser: has_byte; tlast: final_res
//  cfg_*        in   addr 0 mode, addr 1 out_capacity              cfg_wr_en
//
// One input request is classified per cycle while s_tready is high and no register is written;
// the single output register sends one result per cycle while the sink is ready, and encoding
// makes 4 results per 3 inputs.
// A request is stored in the request queue; its results then pass the output register to m_*.
// A 4-entry request queue lets the input side keep going while the output stalls;
// s_tready drops only while that queue is full.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none
module base64url_permuted_codec_top #(
    parameter int LEN_BITS = b64pc_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [b64pc_pkg::IN_TDATA_W-1:0]      s_tdata,   // data[7:0]
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [b64pc_pkg::OUT_TDATA_W-1:0]          m_tdata,   // out_byte, status, out_len
    output logic                                       m_tuser,   // has_byte
    output logic                                       m_tlast,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [b64pc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [b64pc_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    logic                   in_fire;
    logic                   push;
    b64pc_pkg::job_t        push_job;
    logic [LEN_BITS-1:0]    push_len;
    logic                   pop;
    b64pc_pkg::job_t        head_job;
    logic [LEN_BITS-1:0]    head_len;
    logic                   q_full;
    logic                   q_empty;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && !q_full;

    b64pc_front #(.LEN_BITS(LEN_BITS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_data     (s_tdata[7:0]),
        .in_last     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .push_job    (push_job),
        .push_len    (push_len)
    );

    b64pc_queue #(.LEN_BITS(LEN_BITS)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .push_len (push_len),
        .pop      (pop),
        .head_job (head_job),
        .head_len (head_len),
        .full     (q_full),
        .empty    (q_empty)
    );

    b64pc_back #(.LEN_BITS(LEN_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .head_len (head_len),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// File: tb/codec_result_checker.sv
// Stream checker for the base64url codec: predicts every result and compares the output stream.
`timescale 1ns / 1ps
module codec_result_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,     // data[7:0]
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,     // out_byte[7:0], status[11:8], out_len[27:12]
    input  wire logic        m_tuser,     // has_byte
    input  wire logic        m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wr_data,
    output int               fail_count,
    output int               pending,
    output int               result_count,
    output logic [15:0]      codes_seen
);

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               has_byte;
        logic               final_res;
        b64pc_pkg::status_t status;
        logic [15:0]        out_len;
    } codec_out_t;

    localparam logic [8*64-1:0] SYMBOLS =
        "zARij0BS1CkTUD2l3mEVnF4WX5GopH6Y7qZIrJ8asK9bct-L_MduevNwOfgxP=yh";

    codec_out_t  codec_outputs_q[$];
    logic        dec_mode;
    int unsigned capacity;
    logic [23:0] hold;
    int unsigned fill;
    int unsigned written;
    logic        draining;
    logic        started;

    function automatic logic [7:0] symbol_of(input logic [5:0] code);
        return SYMBOLS[8*(63 - code) +: 8];
    endfunction

    // bit 6 set when the character is not in the alphabet
    function automatic logic [6:0] code_of(input logic [7:0] c);
        logic [6:0] found;
        found = 7'h40;
        for (int i = 0; i < 64; i++)
            if (symbol_of(6'(i)) == c) found = 7'(i);
        return found;
    endfunction

    function automatic void restart_message();
        hold = '0;
        fill = 0;
        written = 0;
        draining = 1'b0;
        started = 1'b0;
    endfunction

    function automatic void raise_error(input b64pc_pkg::status_t code, input logic fin);
        codec_out_t r;
        r.out_byte = 8'h00;
        r.has_byte = 1'b0;
        r.final_res = 1'b1;
        r.status = code;
        r.out_len = 16'(written);
        codec_outputs_q.push_back(r);
        if (fin) begin
            restart_message();
        end else begin
            draining = 1'b1;
            hold = '0;
            fill = 0;
        end
    endfunction

    function automatic void emit_group(input logic [31:0] bytes, input int n, input logic fin);
        codec_out_t r;
        for (int k = 0; k < n; k++) begin
            written = (written + 1) & 32'hFFFF;
            r.out_byte = bytes[8*k +: 8];
            r.has_byte = 1'b1;
            r.final_res = fin && (k == n - 1);
            r.status = b64pc_pkg::ST_OK;
            r.out_len = 16'(written);
            codec_outputs_q.push_back(r);
        end
        hold = '0;
        fill = 0;
        if (fin) restart_message();
    endfunction

    function automatic void codec_step(input logic [7:0] data, input logic fin);
        int unsigned n;
        int          nb;
        logic [6:0]  code;
        logic [23:0] val;
        logic [31:0] chars;
        if (draining) begin
            if (fin) restart_message();
            return;
        end
        if (!dec_mode) begin
            if (!started && capacity < 4) begin
                raise_error(b64pc_pkg::ST_ENC_CAP, fin);
                return;
            end
            started = 1'b1;
            hold = hold | (24'(data) << (8 * fill));
            n = fill + 1;
            if (n < 3 && !fin) begin
                fill = n;
                return;
            end
            if (written + 4 > capacity) begin
                raise_error(b64pc_pkg::ST_ENC_FULL, fin);
                return;
            end
            chars[7:0]   = symbol_of(hold[5:0]);
            chars[15:8]  = symbol_of(hold[11:6]);
            chars[23:16] = (n >= 2) ? symbol_of(hold[17:12]) : b64pc_pkg::PAD_CHAR;
            chars[31:24] = (n >= 3) ? symbol_of(hold[23:18]) : b64pc_pkg::PAD_CHAR;
            emit_group(chars, 4, fin);
        end else begin
            code = code_of(data);
            started = 1'b1;
            if (fill < 3) begin
                hold = hold | (24'(code[5:0]) << (6 * fill)) | (24'(code[6]) << (18 + fill));
                fill++;
                if (fin) raise_error(b64pc_pkg::ST_LEN, 1'b1);
                return;
            end
            if (hold[18] || hold[19]) begin
                raise_error(b64pc_pkg::ST_BAD_LEAD, fin);
                return;
            end
            if (!code[6]) begin
                if (hold[20]) begin
                    raise_error(b64pc_pkg::ST_BAD_THIRD, fin);
                    return;
                end
                nb = 3;
                val = {code[5:0], hold[17:0]};
            end else if (!hold[20]) begin
                nb = 2;
                val = {6'd0, hold[17:0]};
            end else begin
                nb = 1;
                val = {12'd0, hold[11:0]};
            end
            if (written + nb > capacity) begin
                raise_error(nb == 3 ? b64pc_pkg::ST_ROOM3 :
                            nb == 2 ? b64pc_pkg::ST_ROOM2 : b64pc_pkg::ST_ROOM1, fin);
                return;
            end
            emit_group({8'h00, val}, nb, fin);
        end
    endfunction

    always @(posedge aclk) begin : watch
        codec_out_t seen;
        codec_out_t want;
        if (!aresetn) begin
            codec_outputs_q.delete();
            dec_mode = 1'b0;
            capacity = 65535;
            restart_message();
            fail_count = 0;
            result_count = 0;
            codes_seen = '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == b64pc_pkg::REG_MODE) begin
                    dec_mode = cfg_wr_data[0];
                    restart_message();
                end else if (cfg_addr == b64pc_pkg::REG_CAP) begin
                    capacity = cfg_wr_data;
                end
            end
            if (m_tvalid && m_tready) begin
                seen.out_byte = m_tdata[7:0];
                seen.has_byte = m_tuser;
                seen.final_res = m_tlast;
                seen.status = b64pc_pkg::status_t'(m_tdata[11:8]);
                seen.out_len = m_tdata[27:12];
                result_count++;
                codes_seen[m_tdata[11:8]] = 1'b1;
                if (codec_outputs_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result byte %02h has %0d fin %0d code %0d len %0d",
                                 $time, seen.out_byte, seen.has_byte, seen.final_res,
                                 seen.status, seen.out_len);
                end else begin
                    want = codec_outputs_q.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch, expected byte %02h has %0d fin %0d code %0d",
                                      " len %0d, got byte %02h has %0d fin %0d code %0d len %0d"},
                                     $time, want.out_byte, want.has_byte, want.final_res,
                                     want.status, want.out_len, seen.out_byte, seen.has_byte,
                                     seen.final_res, seen.status, seen.out_len);
                    end
                end
            end
            if (s_tvalid && s_tready) codec_step(s_tdata, s_tlast);
        end
        pending <= codec_outputs_q.size();
    end

endmodule

// File: tb/tb_top.sv
// Top of the codec testbench: clock, reset, register writes, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0]  REG_UNUSED  = 2'd3;
    localparam logic [15:0] MODE_ENCODE = 16'd0;
    localparam logic [15:0] MODE_DECODE = 16'd1;

    typedef enum int {RDY_OPEN, RDY_COIN, RDY_SLOW, RDY_TOGGLE} ready_pattern_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = 2'd0;
    logic [15:0] cfg_wr_data = 16'd0;

    int             fail_count;
    int             pending;
    int             result_count;
    logic [15:0]    codes_seen;
    int             items_sent = 0;
    int             burst_left = 0;
    ready_pattern_t rdy_pattern = RDY_OPEN;
    int             rdy_left = 0;

    base64url_permuted_codec_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    codec_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count),
        .codes_seen(codes_seen)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rdy_left == 0) begin
                rdy_pattern = ready_pattern_t'($urandom_range(0, 3));
                rdy_left = $urandom_range(8, 120);
            end
            rdy_left--;
            case (rdy_pattern)
                RDY_OPEN: m_tready <= 1'b1;
                RDY_COIN: m_tready <= ($urandom_range(0, 1) == 1);
                RDY_SLOW: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    task automatic send_item(input logic [7:0] d, input logic fin);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    // hold the sender until every predicted result is out, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_item(txt[i], i == txt.len() - 1);
    endtask

    task automatic send_bytes_msg();
        int         len;
        logic [7:0] b;
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_item(b, i == len - 1);
        end
    endtask

    // half well-formed groups; the rest padded, corrupted, truncated or pure noise
    task automatic send_chars_msg();
        logic [7:0] msg[$];
        int         groups;
        int         pos;
        int         kind;
        groups = $urandom_range(1, 3);
        for (int i = 0; i < 4 * groups; i++)
            msg.push_back(b64pc_pkg::ALPHABET[$urandom_range(0, 63)]);
        kind = $urandom_range(0, 9);
        pos = msg.size() - 1;
        case (kind)
            5: msg[pos] = $urandom_range(0, 1) ? b64pc_pkg::PAD_CHAR
                                                : 8'($urandom_range(128, 255));
            6: begin
                msg[pos] = b64pc_pkg::PAD_CHAR;
                msg[pos - 1] = $urandom_range(0, 1) ? b64pc_pkg::PAD_CHAR
                                                     : 8'($urandom_range(128, 255));
            end
            7: msg[$urandom_range(0, pos)] = 8'($urandom_range(0, 255));
            8: repeat ($urandom_range(1, 3)) void'(msg.pop_back());
            9: begin
                msg.delete();
                repeat ($urandom_range(1, 9)) msg.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        for (int i = 0; i < msg.size(); i++) send_item(msg[i], i == msg.size() - 1);
    endtask

    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int          phase_start;
        logic [15:0] cap_val;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(b64pc_pkg::REG_CAP, 16'hFFFF);
        write_reg(b64pc_pkg::REG_MODE, MODE_ENCODE);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b1);
        wait_idle();
        write_reg(b64pc_pkg::REG_CAP, 16'd3);
        send_item(8'hAA, 1'b1);
        wait_idle();
        write_reg(b64pc_pkg::REG_CAP, 16'd4);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h03, 1'b0);
        send_item(8'h04, 1'b1);
        wait_idle();
        write_reg(b64pc_pkg::REG_MODE, MODE_DECODE);
        write_reg(b64pc_pkg::REG_CAP, 16'hFFFF);
        send_text("hhhhzAQQ");
        send_text("zAQzz");
        send_text("zA");

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph)
                0, 1, 6, 7: cap_val = 16'hFFFF;
                2, 3: cap_val = 16'($urandom_range(4, 40));
                4: cap_val = 16'($urandom_range(0, 12));
                default: cap_val = 16'h0000;
            endcase
            write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
            write_reg(b64pc_pkg::REG_MODE, (ph % 2 == 0) ? MODE_ENCODE : MODE_DECODE);
            write_reg(b64pc_pkg::REG_CAP, cap_val);
            phase_start = items_sent;
            while (items_sent - phase_start < 33) begin
                if (ph % 2 == 0) send_bytes_msg();
                else send_chars_msg();
            end
            // leave a message open so the next mode write has to abort it
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("run covered %0d input requests and %0d results in both modes",
                 items_sent, result_count);
        $display("result codes observed (one bit per code): %b", codes_seen[8:0]);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/b64pc_pkg.sv
hdl/b64pc_front.sv
hdl/b64pc_queue.sv
hdl/b64pc_back.sv
hdl/base64url_permuted_codec_top.sv
tb/codec_result_checker.sv
tb/tb_top.sv
